### rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg - shared types and constants for the keypad code lock
// Key codes, result status codes, lock modes and fixed code geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

	// fixed code geometry: four bcd digits per code
	localparam int CODE_DIGITS = 4;
	localparam int CODE_W      = 4 * CODE_DIGITS;
	localparam int CNT_W       = 3;
	localparam int USER_W      = 3;
	localparam int VAL_W       = 14;
	localparam int LIMIT_W     = 4;
	localparam int CFG_DATA_W  = 14;
	localparam int CFG_IDX_W   = 1;

	localparam int USER_COUNT_DEFAULT = 3;

	// reset values of the configuration registers
	localparam logic [LIMIT_W-1:0] ATTEMPT_LIMIT_RST = 4'd3;
	localparam logic [VAL_W-1:0]   VALUE_LIMIT_RST   = 14'd255;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT   = 1'b1;

	// key codes
	localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [3:0] KEY_ENTER     = 4'd10;
	localparam logic [3:0] KEY_EXIT      = 4'd11;
	localparam logic [3:0] KEY_EDIT      = 4'd13;
	localparam logic [3:0] KEY_CANCEL    = 4'd14;

	localparam logic [3:0] WRONG_MAX = 4'd15;

	typedef enum logic [1:0] {
		MODE_VERIFY = 2'd0,
		MODE_USER   = 2'd1,
		MODE_OLD    = 2'd2,
		MODE_NEW    = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		STS_IGNORED  = 4'd0,
		STS_DIGIT    = 4'd1,
		STS_UNLOCK   = 4'd2,
		STS_WRONG    = 4'd3,
		STS_LOCKOUT  = 4'd4,
		STS_SHORT    = 4'd5,
		STS_BAD_USER = 4'd6,
		STS_USER_OK  = 4'd7,
		STS_OLD_OK   = 4'd8,
		STS_OLD_BAD  = 4'd9,
		STS_RANGE    = 4'd10,
		STS_CHANGED  = 4'd11,
		STS_CLEARED  = 4'd12,
		STS_RESET    = 4'd13,
		STS_RELEASED = 4'd14,
		STS_MODIFY   = 4'd15
	} status_t;

endpackage

`default_nettype wire

### rtl/keypad_code_lock_controller.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_controller - multi-user keypad combination lock
// Takes decoded key codes, keeps the code entry, the per-user codes and the
// error/lockout state, and returns one status request per key.
// ----------------------------------------------------------------------------
// an accepted key is held in the input register, then its result goes into the result register
// throughput: one key per cycle while results are taken; the state update sits between the two registers
// ready only drops while a result is held and out_ready is low with a key waiting
// reset: arst_n clears all control state, limits go to 3 and 255, user codes to 1..n
// user codes hold their values until changed through modify mode or reset
`default_nettype none

module keypad_code_lock_controller #(
	parameter int USER_COUNT = kcl_pkg::USER_COUNT_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data,

	// key input channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [3:0]                     key_code,

	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [3:0]                          status,
	output logic [kcl_pkg::USER_W-1:0]          matched_user,
	output logic [3:0]                          error_count,
	output logic                                locked_out,
	output logic [kcl_pkg::CNT_W-1:0]           digits_entered,
	output logic [1:0]                          mode
);

	// width of an index into the code store
	localparam int UIDX_W = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
	localparam logic [3:0] USER_KEY_MAX = 4'(USER_COUNT);
	localparam logic [kcl_pkg::CNT_W-1:0] FULL_CNT = kcl_pkg::CNT_W'(kcl_pkg::CODE_DIGITS);
	// user count one bit wider than a user index, so eight users still compare
	localparam logic [kcl_pkg::USER_W:0] USER_NUM = (kcl_pkg::USER_W+1)'(USER_COUNT);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [kcl_pkg::LIMIT_W-1:0] attempt_limit_q;
	logic [kcl_pkg::VAL_W-1:0]   value_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_limit_q <= kcl_pkg::ATTEMPT_LIMIT_RST;
			value_limit_q   <= kcl_pkg::VALUE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kcl_pkg::CFG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_data[kcl_pkg::LIMIT_W-1:0];
				kcl_pkg::CFG_VALUE_LIMIT:   value_limit_q   <= cfg_data[kcl_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// input register and handshake
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [3:0] key_s1;
	logic       out_valid_q;
	logic       adv;

	// the held key is processed when the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1 <= key_code;
		end
	end

	// ------------------------------------------------------------------
	// lock state
	// ------------------------------------------------------------------
	logic [kcl_pkg::CODE_W-1:0] store_q [USER_COUNT];
	logic [kcl_pkg::CODE_W-1:0] entry_q;
	logic [kcl_pkg::CNT_W-1:0]  cnt_q;
	logic [3:0]                 wrong_q;
	logic                       lock_q;
	kcl_pkg::mode_t             mode_q;
	logic [kcl_pkg::USER_W-1:0] target_q;

	// ------------------------------------------------------------------
	// key processing
	// ------------------------------------------------------------------
	logic [kcl_pkg::CODE_W-1:0] n_entry;
	logic [kcl_pkg::CNT_W-1:0]  n_cnt;
	logic [3:0]                 n_wrong;
	logic                       n_lock;
	kcl_pkg::mode_t             n_mode;
	logic [kcl_pkg::USER_W-1:0] n_target;
	kcl_pkg::status_t           n_status;
	logic [kcl_pkg::USER_W-1:0] n_match;
	logic                       store_we;

	logic [kcl_pkg::VAL_W-1:0]  entry_val;
	logic [UIDX_W-1:0]          tu_idx;
	logic                       hit;
	logic [kcl_pkg::USER_W-1:0] hit_idx;
	logic [3:0]                 wrong_inc;

	// decimal value of the bcd entry, at most 9999
	assign entry_val = kcl_pkg::VAL_W'({10'd0, entry_q[15:12]} * 14'd1000)
	                 + kcl_pkg::VAL_W'({10'd0, entry_q[11:8]}  * 14'd100)
	                 + kcl_pkg::VAL_W'({10'd0, entry_q[7:4]}   * 14'd10)
	                 + kcl_pkg::VAL_W'({10'd0, entry_q[3:0]});

	// out-of-range target falls back to user 0
	assign tu_idx = ({1'b0, target_q} < USER_NUM) ? target_q[UIDX_W-1:0] : '0;

	// saturating error count
	assign wrong_inc = (wrong_q != kcl_pkg::WRONG_MAX) ? wrong_q + 4'd1 : wrong_q;

	// parallel compare, lowest matching user wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = USER_COUNT - 1; i >= 0; i--) begin
			if (store_q[i] == entry_q) begin
				hit     = 1'b1;
				hit_idx = kcl_pkg::USER_W'(i);
			end
		end
	end

	always_comb begin
		n_entry  = entry_q;
		n_cnt    = cnt_q;
		n_wrong  = wrong_q;
		n_lock   = lock_q;
		n_mode   = mode_q;
		n_target = target_q;
		n_status = kcl_pkg::STS_IGNORED;
		n_match  = '0;
		store_we = 1'b0;

		priority if (lock_q) begin
			// only clear releases a lockout
			if (key_s1 == kcl_pkg::KEY_CANCEL) begin
				n_lock   = 1'b0;
				n_wrong  = '0;
				n_cnt    = '0;
				n_status = kcl_pkg::STS_RELEASED;
			end
		end else if (key_s1 == kcl_pkg::KEY_EDIT) begin
			if (mode_q == kcl_pkg::MODE_VERIFY) begin
				n_mode   = kcl_pkg::MODE_USER;
				n_cnt    = '0;
				n_status = kcl_pkg::STS_MODIFY;
			end
		end else if (key_s1 == kcl_pkg::KEY_CANCEL) begin
			n_cnt    = '0;
			n_status = kcl_pkg::STS_CLEARED;
		end else if (key_s1 == kcl_pkg::KEY_EXIT) begin
			n_mode   = kcl_pkg::MODE_VERIFY;
			n_cnt    = '0;
			n_wrong  = '0;
			n_status = kcl_pkg::STS_RESET;
		end else if (key_s1 <= kcl_pkg::KEY_DIGIT_MAX) begin
			if (cnt_q < FULL_CNT) begin
				if (mode_q == kcl_pkg::MODE_USER) begin
					// digit picks a user, 1-based
					if (key_s1 >= 4'd1 && key_s1 <= USER_KEY_MAX) begin
						n_target = kcl_pkg::USER_W'(key_s1 - 4'd1);
						n_mode   = kcl_pkg::MODE_OLD;
						n_cnt    = '0;
						n_status = kcl_pkg::STS_USER_OK;
					end else begin
						n_status = kcl_pkg::STS_BAD_USER;
					end
				end else begin
					n_entry  = {entry_q[kcl_pkg::CODE_W-5:0], key_s1};
					n_cnt    = cnt_q + 1'b1;
					n_status = kcl_pkg::STS_DIGIT;
				end
			end
		end else if (key_s1 == kcl_pkg::KEY_ENTER) begin
			if (cnt_q == FULL_CNT) begin
				unique case (mode_q)
					kcl_pkg::MODE_VERIFY: begin
						if (hit) begin
							n_wrong  = '0;
							n_match  = hit_idx;
							n_status = kcl_pkg::STS_UNLOCK;
						end else begin
							n_wrong = wrong_inc;
							if (wrong_inc >= attempt_limit_q) begin
								n_lock   = 1'b1;
								n_status = kcl_pkg::STS_LOCKOUT;
							end else begin
								n_status = kcl_pkg::STS_WRONG;
							end
						end
					end
					kcl_pkg::MODE_OLD: begin
						// old-code misses do not count as errors
						if (entry_val > value_limit_q) begin
							n_mode   = kcl_pkg::MODE_VERIFY;
							n_status = kcl_pkg::STS_RANGE;
						end else if (store_q[tu_idx] == entry_q) begin
							n_mode   = kcl_pkg::MODE_NEW;
							n_status = kcl_pkg::STS_OLD_OK;
						end else begin
							n_mode   = kcl_pkg::MODE_VERIFY;
							n_status = kcl_pkg::STS_OLD_BAD;
						end
					end
					kcl_pkg::MODE_NEW: begin
						if (entry_val <= value_limit_q) begin
							store_we = 1'b1;
							n_status = kcl_pkg::STS_CHANGED;
						end else begin
							n_status = kcl_pkg::STS_RANGE;
						end
						n_mode = kcl_pkg::MODE_VERIFY;
					end
					kcl_pkg::MODE_USER: ;
					default: ;
				endcase
				n_cnt = '0;
			end else if (cnt_q != '0) begin
				// partial entry is thrown away
				n_cnt    = '0;
				n_status = kcl_pkg::STS_SHORT;
			end
		end else begin
			// spare keys have no function
		end
	end

	// ------------------------------------------------------------------
	// state update
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			cnt_q    <= '0;
			wrong_q  <= '0;
			lock_q   <= 1'b0;
			mode_q   <= kcl_pkg::MODE_VERIFY;
			target_q <= '0;
		end else if (adv) begin
			entry_q  <= n_entry;
			cnt_q    <= n_cnt;
			wrong_q  <= n_wrong;
			lock_q   <= n_lock;
			mode_q   <= n_mode;
			target_q <= n_target;
		end
	end

	// user code store, user i starts with bcd code i+1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < USER_COUNT; i++) begin
				store_q[i] <= kcl_pkg::CODE_W'(i + 1);
			end
		end else if (adv && store_we) begin
			store_q[tu_idx] <= entry_q;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	kcl_pkg::status_t           status_q;
	logic [kcl_pkg::USER_W-1:0] match_q;
	logic [3:0]                 err_q;
	logic                       lock_out_q;
	logic [kcl_pkg::CNT_W-1:0]  digits_q;
	kcl_pkg::mode_t             mode_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q   <= n_status;
			match_q    <= n_match;
			err_q      <= n_wrong;
			lock_out_q <= n_lock;
			digits_q   <= n_cnt;
			mode_out_q <= n_mode;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign matched_user   = match_q;
	assign error_count    = err_q;
	assign locked_out     = lock_out_q;
	assign digits_entered = digits_q;
	assign mode           = mode_out_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_lock_has_errors: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q |-> (wrong_q != 4'd0))
		else $error("lockout held with zero error count");

	a_entry_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count beyond code length");

	a_target_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, target_q} < USER_NUM)
		else $error("target user out of range");

	a_unlock_clears_errors: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == kcl_pkg::STS_UNLOCK)
			|-> (err_q == 4'd0 && !lock_out_q))
		else $error("unlock result with errors pending");

	a_processed_key_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed key produced no result");

endmodule

`default_nettype wire

### tb/tb_keypad_code_lock_controller.sv
// ----------------------------------------------------------------------------
// tb_keypad_code_lock_controller - self-checking bench for the keypad lock
// Drives decoded keys through the valid/ready key channel with random gaps
// and result backpressure. A cycle-free model of the lock runs beside the
// block and predicts status, matched user, error count, lockout, entry depth
// and mode for every accepted key. A short directed table comes first, then
// phases of random keypad sessions under several limit settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keypad_code_lock_controller;

	import kcl_pkg::*;

	localparam int NUM_USERS      = USER_COUNT_DEFAULT;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PHASES         = 8;
	localparam int REQ_PER_PHASE  = 80;
	localparam int DIR_ROWS       = 33;
	localparam int SETTLE_CYCLES  = 4;

	// keys with no function, named for the table
	localparam logic [3:0] KEY_SPARE_LO = 4'd12;
	localparam logic [3:0] KEY_SPARE_HI = 4'd15;

	// one result request as the block reports it
	typedef struct packed {
		status_t           st;
		logic [USER_W-1:0] user;
		logic [3:0]        errs;
		logic              lock;
		logic [CNT_W-1:0]  digs;
		mode_t             md;
	} lock_result_t;

	// one directed row: key, and a status typed in where it is obvious
	typedef struct packed {
		logic      pinned;
		status_t   st;
		logic [3:0] key;
	} key_row_t;

	// ------------------------------------------------------------------
	// clock, reset and block signals
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] key_code = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] status;
	logic [USER_W-1:0] matched_user;
	logic [3:0] error_count;
	logic locked_out;
	logic [CNT_W-1:0] digits_entered;
	logic [1:0] mode;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	keypad_code_lock_controller #(
		.USER_COUNT(NUM_USERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key_code(key_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.matched_user(matched_user),
		.error_count(error_count),
		.locked_out(locked_out),
		.digits_entered(digits_entered),
		.mode(mode)
	);

	// ------------------------------------------------------------------
	// lock model state: limits, stored codes and session state
	// ------------------------------------------------------------------
	logic [LIMIT_W-1:0] lim_attempts;
	logic [VAL_W-1:0]   lim_value;
	logic [CODE_W-1:0]  stored [NUM_USERS];
	logic [CODE_W-1:0]  entry;
	logic [CNT_W-1:0]   held;
	logic [3:0]         wrongs;
	logic               locked;
	mode_t              cur_mode;
	logic [USER_W-1:0]  target;

	lock_result_t results_due [$];
	int mismatches = 0;
	int counted = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	int stall_left = 0;

	function automatic int bcd_to_dec(logic [CODE_W-1:0] b);
		return b[15:12] * 1000 + b[11:8] * 100 + b[7:4] * 10 + b[3:0];
	endfunction

	function automatic logic [CODE_W-1:0] dec_to_bcd(int unsigned v);
		return {4'(v / 1000), 4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
	endfunction

	function automatic logic [CODE_W-1:0] rand_code();
		return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
			4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
	endfunction

	// advance the lock model by one key and return the status it reports
	function automatic lock_result_t lock_step(logic [3:0] k);
		lock_result_t r;
		int val;
		bit hit;
		r = '0;
		r.st = STS_IGNORED;
		if (locked) begin
			// only clear gets through a lockout
			if (k == KEY_CANCEL) begin
				locked = 1'b0;
				wrongs = '0;
				held = '0;
				r.st = STS_RELEASED;
			end
		end else if (k == KEY_EDIT) begin
			if (cur_mode == MODE_VERIFY) begin
				cur_mode = MODE_USER;
				held = '0;
				r.st = STS_MODIFY;
			end
		end else if (k == KEY_CANCEL) begin
			held = '0;
			r.st = STS_CLEARED;
		end else if (k == KEY_EXIT) begin
			cur_mode = MODE_VERIFY;
			held = '0;
			wrongs = '0;
			r.st = STS_RESET;
		end else if (k <= KEY_DIGIT_MAX) begin
			if (held < CODE_DIGITS) begin
				if (cur_mode == MODE_USER) begin
					// user pick is one-based on the keypad
					if (k >= 1 && k <= NUM_USERS) begin
						target = USER_W'(k - 1);
						cur_mode = MODE_OLD;
						held = '0;
						r.st = STS_USER_OK;
					end else begin
						r.st = STS_BAD_USER;
					end
				end else begin
					entry = {entry[11:0], k};
					held = held + 1'b1;
					r.st = STS_DIGIT;
				end
			end
		end else if (k == KEY_ENTER) begin
			if (held == CODE_DIGITS) begin
				val = bcd_to_dec(entry);
				if (cur_mode == MODE_VERIFY) begin
					hit = 1'b0;
					for (int i = 0; i < NUM_USERS; i++) begin
						if (!hit && stored[i] == entry) begin
							hit = 1'b1;
							r.user = USER_W'(i);
						end
					end
					if (hit) begin
						wrongs = '0;
						r.st = STS_UNLOCK;
					end else begin
						if (wrongs < WRONG_MAX)
							wrongs = wrongs + 1'b1;
						if (wrongs >= lim_attempts) begin
							locked = 1'b1;
							r.st = STS_LOCKOUT;
						end else begin
							r.st = STS_WRONG;
						end
					end
				end else if (cur_mode == MODE_OLD) begin
					// old-code misses never count as errors
					if (val > lim_value) begin
						cur_mode = MODE_VERIFY;
						r.st = STS_RANGE;
					end else if (stored[target] == entry) begin
						cur_mode = MODE_NEW;
						r.st = STS_OLD_OK;
					end else begin
						cur_mode = MODE_VERIFY;
						r.st = STS_OLD_BAD;
					end
				end else if (cur_mode == MODE_NEW) begin
					if (val <= lim_value) begin
						stored[target] = entry;
						r.st = STS_CHANGED;
					end else begin
						r.st = STS_RANGE;
					end
					cur_mode = MODE_VERIFY;
				end
				held = '0;
			end else if (held > 0) begin
				held = '0;
				r.st = STS_SHORT;
			end
		end
		r.errs = wrongs;
		r.lock = locked;
		r.digs = held;
		r.md = cur_mode;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// key channel driver
	// ------------------------------------------------------------------

	// present one key, hold it until accepted, then queue its predicted result
	task automatic send_key(input logic [3:0] k, input bit pinned,
		input status_t pinned_st);
		lock_result_t want;
		// random idle burst ahead of the request
		if (!calm && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		key_code <= k;
		do
			@(posedge clk);
		while (!in_ready);
		want = lock_step(k);
		if (pinned)
			want.st = pinned_st;
		counted++;
		results_due.push_back(want);
	endtask

	task automatic press(input logic [3:0] k);
		send_key(k, 1'b0, STS_IGNORED);
	endtask

	// digits go in most significant first, the block shifts them up
	task automatic send_code(input logic [CODE_W-1:0] code);
		for (int i = CODE_DIGITS - 1; i >= 0; i--)
			press(code[i*4 +: 4]);
	endtask

	// stop sending and wait for every outstanding result request
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// config writes happen only with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ATTEMPT_LIMIT)
			lim_attempts = data[LIMIT_W-1:0];
		else
			lim_value = data[VAL_W-1:0];
	endtask

	// one random keypad session, mostly well formed
	task automatic run_session();
		int pick;
		int u;
		int bad;
		logic [CODE_W-1:0] code;
		pick = $urandom_range(0, 99);
		u = $urandom_range(0, NUM_USERS - 1);
		if (pick < 30) begin
			// a valid user code
			send_code(stored[u]);
			press(KEY_ENTER);
		end else if (pick < 50) begin
			// almost always a miss
			send_code(rand_code());
			press(KEY_ENTER);
		end else if (pick < 75) begin
			// full code change, with the odd bad pick or wrong code
			press(KEY_EDIT);
			if ($urandom_range(0, 4) == 0) begin
				bad = $urandom_range(0, 9 - NUM_USERS);
				press(bad == 0 ? 4'd0 : 4'(NUM_USERS + bad));
			end
			press(4'(u + 1));
			code = ($urandom_range(0, 4) != 0) ? stored[u] : rand_code();
			send_code(code);
			press(KEY_ENTER);
			code = ($urandom_range(0, 4) != 0) ?
				dec_to_bcd($urandom_range(0, lim_value)) : rand_code();
			send_code(code);
			press(KEY_ENTER);
		end else if (pick < 80) begin
			// short entry
			repeat ($urandom_range(1, 3)) press(4'($urandom_range(0, 9)));
			press(KEY_ENTER);
		end else if (pick < 88) begin
			press(KEY_CANCEL);
		end else if (pick < 92) begin
			press(KEY_EXIT);
		end else begin
			// raw noise over the whole key range
			repeat ($urandom_range(1, 6)) press(4'($urandom_range(0, 15)));
		end
	endtask

	// ------------------------------------------------------------------
	// result side: random backpressure and the checker
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			// random burst of stalled cycles
			stall_left = $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		lock_result_t want;
		lock_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.st = status_t'(status);
			got.user = matched_user;
			got.errs = error_count;
			got.lock = locked_out;
			got.digs = digits_entered;
			got.md = mode_t'(mode);
			if (results_due.size() == 0) begin
				// result with nothing outstanding
				mismatches++;
				if (mismatches <= 10)
					$display(
						"unexpected result: st %0d user %0d errs %0d lock %0b digs %0d mode %0d",
						got.st, got.user, got.errs, got.lock, got.digs, got.md);
			end else begin
				want = results_due.pop_front();
				if (got.st != want.st || got.user != want.user || got.errs != want.errs ||
				    got.lock != want.lock || got.digs != want.digs || got.md != want.md) begin
					mismatches++;
					// fields in order: status, user, errors, lock, digits, mode
					if (mismatches <= 10)
						$display(
							"mismatch: expected %0d %0d %0d %0b %0d %0d got %0d %0d %0d %0b %0d %0d",
							want.st, want.user, want.errs, want.lock, want.digs, want.md,
							got.st, got.user, got.errs, got.lock, got.digs, got.md);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		key_row_t dir_rows [DIR_ROWS];
		logic [CFG_DATA_W-1:0] data;
		int goal;
		int ph;
		int att;
		int vlim;

		// model reset state mirrors the block reset
		lim_attempts = ATTEMPT_LIMIT_RST;
		lim_value = VALUE_LIMIT_RST;
		for (int i = 0; i < NUM_USERS; i++)
			stored[i] = CODE_W'(i + 1);
		entry = '0;
		held = '0;
		wrongs = '0;
		locked = 1'b0;
		cur_mode = MODE_VERIFY;
		target = '0;

		// directed walk at reset limits: attempts 3, code value 255
		dir_rows = '{
			'{1'b1, STS_IGNORED,  KEY_SPARE_LO},
			'{1'b1, STS_IGNORED,  KEY_ENTER},     // confirm on empty entry
			'{1'b1, STS_DIGIT,    4'd0},
			'{1'b1, STS_DIGIT,    4'd0},
			'{1'b1, STS_DIGIT,    4'd0},
			'{1'b1, STS_DIGIT,    4'd2},
			'{1'b1, STS_IGNORED,  4'd9},          // fifth digit dropped
			'{1'b1, STS_UNLOCK,   KEY_ENTER},     // second user's reset code
			'{1'b1, STS_IGNORED,  KEY_SPARE_HI},
			'{1'b1, STS_DIGIT,    4'd7},
			'{1'b1, STS_SHORT,    KEY_ENTER},
			'{1'b1, STS_MODIFY,   KEY_EDIT},
			'{1'b1, STS_IGNORED,  KEY_EDIT},      // modify while already modifying
			'{1'b1, STS_BAD_USER, 4'd9},
			'{1'b1, STS_USER_OK,  4'd3},
			'{1'b1, STS_DIGIT,    4'd5},
			'{1'b1, STS_CLEARED,  KEY_CANCEL},
			'{1'b0, STS_IGNORED,  4'd0},
			'{1'b0, STS_IGNORED,  4'd0},
			'{1'b0, STS_IGNORED,  4'd0},
			'{1'b0, STS_IGNORED,  4'd3},
			'{1'b1, STS_OLD_OK,   KEY_ENTER},
			'{1'b0, STS_IGNORED,  4'd9},
			'{1'b0, STS_IGNORED,  4'd9},
			'{1'b0, STS_IGNORED,  4'd9},
			'{1'b0, STS_IGNORED,  4'd9},
			'{1'b1, STS_RANGE,    KEY_ENTER},     // new code above the limit
			'{1'b0, STS_IGNORED,  4'd1},
			'{1'b0, STS_IGNORED,  4'd2},
			'{1'b0, STS_IGNORED,  4'd3},
			'{1'b0, STS_IGNORED,  4'd4},
			'{1'b1, STS_WRONG,    KEY_ENTER},
			'{1'b1, STS_RESET,    KEY_EXIT}       // close wipes the error count
		};

		// reset is held low first, then released on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_key(dir_rows[i].key, dir_rows[i].pinned, dir_rows[i].st);

		// random sessions under a range of limit settings
		for (ph = 0; ph < PHASES; ph++) begin
			// idle the key channel until every request is back
			drain();
			calm = (ph == PHASES - 1);
			case (ph)
				0: begin att = 1; vlim = 9999; end
				1: begin att = 15; vlim = 0; end
				2: begin att = 0; vlim = 255; end    // first miss locks out
				3: begin att = 2; vlim = 1234; end
				7: begin att = 3; vlim = 9999; end
				default: begin
					att = $urandom_range(0, 15);
					vlim = $urandom_range(0, 9999);
				end
			endcase
			// junk in the unused upper bits of the attempt register write
			data = CFG_DATA_W'($urandom);
			data[LIMIT_W-1:0] = LIMIT_W'(att);
			write_reg(CFG_ATTEMPT_LIMIT, data);
			write_reg(CFG_VALUE_LIMIT, CFG_DATA_W'(vlim));
			goal = counted + REQ_PER_PHASE;
			while (counted < goal) begin
				run_session();
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### keypad_code_lock_controller.f
rtl/kcl_pkg.sv
rtl/keypad_code_lock_controller.sv
tb/tb_keypad_code_lock_controller.sv
